>>> rtl/core/pcih_pkg.sv
// Shared types and constants for the PCI type-0 configuration header unit.
// Standalone package; no dependencies.

package pcih_pkg;

    // Access operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Header register byte offsets
    localparam logic [7:0] OFS_ID        = 8'h00;
    localparam logic [7:0] OFS_CMD       = 8'h04;
    localparam logic [7:0] OFS_CLASS     = 8'h08;
    localparam logic [7:0] OFS_MISC      = 8'h0C;
    localparam logic [7:0] OFS_BAR_FIRST = 8'h10;
    localparam logic [7:0] OFS_BAR_LAST  = 8'h24;
    localparam logic [7:0] OFS_ROM       = 8'h30;
    localparam logic [7:0] OFS_INTR      = 8'h3C;

    // Byte lanes
    localparam logic [1:0] LANE_0 = 2'd0;
    localparam logic [1:0] LANE_1 = 2'd1;

    // BAR kinds and their type bits
    localparam logic [1:0]  KIND_IO        = 2'd1;
    localparam logic [1:0]  KIND_PREFETCH  = 2'd2;
    localparam logic [31:0] TYPE_BITS_IO   = 32'h0000_0001;
    localparam logic [31:0] TYPE_BITS_PREF = 32'h0000_0008;
    localparam logic [31:0] ROM_ENABLE     = 32'h0000_0001;

    // Bits per BAR in the layout register
    localparam int LAYOUT_BITS = 7;

    // Configuration register indexes (byte address = 8 * index)
    localparam logic [2:0] CFG_ID_WORD      = 3'd0;
    localparam logic [2:0] CFG_CLASS_WORD   = 3'd1;
    localparam logic [2:0] CFG_HDR_PIN      = 3'd2;
    localparam logic [2:0] CFG_CMD_WMASK    = 3'd3;
    localparam logic [2:0] CFG_CMD_RESET    = 3'd4;
    localparam logic [2:0] CFG_STATUS_RESET = 3'd5;
    localparam logic [2:0] CFG_BAR_LAYOUT   = 3'd6;
    localparam logic [2:0] CFG_ROM_SIZE     = 3'd7;

    // One pending access held in the input stage
    typedef struct packed {
        logic       op;
        logic [7:0] reg_offset;
        logic [1:0] byte_lane;
        logic [7:0] write_value;
    } access_t;

endpackage

>>> rtl/core/pci_type0_config_header_unit.sv
// PCI type-0 configuration header: register decode, read assembly and byte writes.
// Depends on pcih_pkg.
//
//  channel | ports                               | transfer when
//  --------+-------------------------------------+----------------------------
//  s_      | op, reg_offset, byte_lane, value    | s_valid && s_ready
//  m_      | read_data, regions_changed          | m_valid && m_ready
//  apb     | psel/penable/pwrite/paddr/pwdata    | psel && penable && pwrite
//
// One access per cycle sustained while m_ready keeps up: an input register feeds
// the decode/merge logic, whose result lands in the output register as the state
// updates are made, so an access crosses the input then the output register.
// With the output stalled, the input stage still takes one more access.
// Synchronous active-low reset zeroes valid flags, header state and configuration.

module pci_type0_config_header_unit #(
    parameter int NUM_BARS = 6
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_reg_offset,
    input  logic [1:0]  s_byte_lane,
    input  logic [7:0]  s_write_value,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_regions_changed,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int LAYOUT_W = NUM_BARS * pcih_pkg::LAYOUT_BITS;

    // Configuration registers
    logic [31:0]         id_word_reg;
    logic [31:0]         class_word_reg;
    logic [15:0]         hdr_pin_reg;
    logic [15:0]         cmd_wmask_reg;
    logic [15:0]         cmd_reset_reg;
    logic [15:0]         status_reset_reg;
    logic [41:0]         bar_layout_reg;
    logic [4:0]          rom_size_reg;

    // Header state
    logic [31:0]         bar_reg [NUM_BARS];
    logic [31:0]         rom_reg;
    logic [15:0]         command_reg;
    logic [7:0]          cache_line_reg;
    logic [7:0]          latency_reg;
    logic [7:0]          irq_line_reg;

    // Pipeline registers
    logic                in_valid_reg;
    pcih_pkg::access_t   in_reg;
    logic                out_valid_reg;
    logic [31:0]         out_data_reg;
    logic                out_changed_reg;

    logic                advance;
    logic                apb_wr_en;
    logic                is_write;
    logic [31:0]         lane_mask;
    logic [31:0]         lane_ins;
    logic [7:0]          bar_rel;
    logic [2:0]          bar_idx;
    logic                bar_win;
    logic [LAYOUT_W-1:0] layout;
    logic [NUM_BARS-1:0] bar_hit;
    logic [NUM_BARS-1:0] bar_diff;
    logic [31:0]         bar_next [NUM_BARS];
    logic [31:0]         bar_rd;
    logic [31:0]         rom_next;
    logic [15:0]         cmd_incoming;
    logic [15:0]         command_next;
    logic                cmd_wr;
    logic                rom_wr;
    logic [31:0]         rd_data;
    logic                changed;

    // Handshake: the input stage moves on whenever the output slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign m_valid  = out_valid_reg;
    assign m_read_data       = out_data_reg;
    assign m_regions_changed = out_changed_reg;

    assign pready    = 1'b1;
    assign apb_wr_en = psel && penable && pwrite && pready;

    // Configuration read-back
    always_comb begin
        case (paddr[5:3])
            pcih_pkg::CFG_ID_WORD:      prdata = {32'd0, id_word_reg};
            pcih_pkg::CFG_CLASS_WORD:   prdata = {32'd0, class_word_reg};
            pcih_pkg::CFG_HDR_PIN:      prdata = {48'd0, hdr_pin_reg};
            pcih_pkg::CFG_CMD_WMASK:    prdata = {48'd0, cmd_wmask_reg};
            pcih_pkg::CFG_CMD_RESET:    prdata = {48'd0, cmd_reset_reg};
            pcih_pkg::CFG_STATUS_RESET: prdata = {48'd0, status_reset_reg};
            pcih_pkg::CFG_BAR_LAYOUT:   prdata = {22'd0, bar_layout_reg};
            pcih_pkg::CFG_ROM_SIZE:     prdata = {59'd0, rom_size_reg};
            default:                    prdata = 64'd0;
        endcase
    end

    // Byte lane merge terms
    assign is_write  = (in_reg.op == pcih_pkg::OP_WRITE);
    assign lane_mask = 32'h0000_00FF << {in_reg.byte_lane, 3'b000};
    assign lane_ins  = {24'd0, in_reg.write_value} << {in_reg.byte_lane, 3'b000};

    // BAR window decode: any offset 0x10..0x24 picks (offset - 0x10) >> 2
    assign bar_rel = in_reg.reg_offset - pcih_pkg::OFS_BAR_FIRST;
    assign bar_idx = bar_rel[4:2];
    assign bar_win = (in_reg.reg_offset >= pcih_pkg::OFS_BAR_FIRST) &&
                     (in_reg.reg_offset <= pcih_pkg::OFS_BAR_LAST);
    assign layout  = bar_layout_reg[LAYOUT_W-1:0];

    // Per-BAR hit, read value and write merge
    always_comb begin
        logic [6:0] fld;
        bar_rd = 32'd0;
        for (int i = 0; i < NUM_BARS; i++) begin
            fld         = layout[i*pcih_pkg::LAYOUT_BITS +: pcih_pkg::LAYOUT_BITS];
            bar_hit[i]  = bar_win && (bar_idx == 3'(i)) && (fld[4:0] != 5'd0);
            bar_next[i] = (bar_reg[i] & ~lane_mask) | lane_ins;
            bar_diff[i] = bar_hit[i] && (bar_next[i] != bar_reg[i]);
            if (bar_hit[i]) begin
                bar_rd = bar_reg[i] & (32'hFFFF_FFFF << fld[4:0]);
                if (fld[6:5] == pcih_pkg::KIND_IO) begin
                    bar_rd = bar_rd | pcih_pkg::TYPE_BITS_IO;
                end else if (fld[6:5] == pcih_pkg::KIND_PREFETCH) begin
                    bar_rd = bar_rd | pcih_pkg::TYPE_BITS_PREF;
                end
            end
        end
    end

    // Command and ROM write values
    assign cmd_wr       = (in_reg.reg_offset == pcih_pkg::OFS_CMD) && !in_reg.byte_lane[1];
    assign cmd_incoming = (command_reg & ~lane_mask[15:0]) | lane_ins[15:0];
    assign command_next = (command_reg & ~cmd_wmask_reg) | (cmd_incoming & cmd_wmask_reg) |
                          cmd_reset_reg;
    assign rom_wr       = (in_reg.reg_offset == pcih_pkg::OFS_ROM) && (rom_size_reg != 5'd0);
    assign rom_next     = (rom_reg & ~lane_mask) | lane_ins;

    // Read assembly
    always_comb begin
        case (in_reg.reg_offset)
            pcih_pkg::OFS_ID:    rd_data = id_word_reg;
            pcih_pkg::OFS_CMD:   rd_data = {status_reset_reg, command_reg};
            pcih_pkg::OFS_CLASS: rd_data = class_word_reg;
            pcih_pkg::OFS_MISC:  rd_data = {8'd0, hdr_pin_reg[15:8], latency_reg,
                                            cache_line_reg};
            pcih_pkg::OFS_ROM: begin
                if (rom_size_reg == 5'd0) begin
                    rd_data = 32'd0;
                end else begin
                    rd_data = (rom_reg & (32'hFFFF_FFFF << rom_size_reg)) |
                              (rom_reg & pcih_pkg::ROM_ENABLE);
                end
            end
            pcih_pkg::OFS_INTR:  rd_data = {16'd0, hdr_pin_reg[7:0], irq_line_reg};
            default:             rd_data = 32'd0;
        endcase
        if (bar_win) begin
            rd_data = bar_rd;
        end
    end

    // Change flag for writes
    assign changed = (|bar_diff) ||
                     (cmd_wr && (command_next != command_reg)) ||
                     (rom_wr && (rom_next != rom_reg));

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_word_reg      <= 32'd0;
            class_word_reg   <= 32'd0;
            hdr_pin_reg      <= 16'd0;
            cmd_wmask_reg    <= 16'd0;
            cmd_reset_reg    <= 16'd0;
            status_reset_reg <= 16'd0;
            bar_layout_reg   <= 42'd0;
            rom_size_reg     <= 5'd0;
        end else if (apb_wr_en) begin
            case (paddr[5:3])
                pcih_pkg::CFG_ID_WORD:      id_word_reg      <= pwdata[31:0];
                pcih_pkg::CFG_CLASS_WORD:   class_word_reg   <= pwdata[31:0];
                pcih_pkg::CFG_HDR_PIN:      hdr_pin_reg      <= pwdata[15:0];
                pcih_pkg::CFG_CMD_WMASK:    cmd_wmask_reg    <= pwdata[15:0];
                pcih_pkg::CFG_CMD_RESET:    cmd_reset_reg    <= pwdata[15:0];
                pcih_pkg::CFG_STATUS_RESET: status_reset_reg <= pwdata[15:0];
                pcih_pkg::CFG_BAR_LAYOUT:   bar_layout_reg   <= pwdata[41:0];
                pcih_pkg::CFG_ROM_SIZE:     rom_size_reg     <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // Header state updates on a write leaving the input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BARS; i++) begin
                bar_reg[i] <= 32'd0;
            end
            rom_reg        <= 32'd0;
            command_reg    <= 16'd0;
            cache_line_reg <= 8'd0;
            latency_reg    <= 8'd0;
            irq_line_reg   <= 8'd0;
        end else if (advance && is_write) begin
            for (int i = 0; i < NUM_BARS; i++) begin
                if (bar_hit[i]) begin
                    bar_reg[i] <= bar_next[i];
                end
            end
            if (cmd_wr) begin
                command_reg <= command_next;
            end
            if (rom_wr) begin
                rom_reg <= rom_next;
            end
            if (in_reg.reg_offset == pcih_pkg::OFS_MISC) begin
                if (in_reg.byte_lane == pcih_pkg::LANE_0) begin
                    cache_line_reg <= in_reg.write_value;
                end else if (in_reg.byte_lane == pcih_pkg::LANE_1) begin
                    latency_reg <= in_reg.write_value;
                end
            end
            if ((in_reg.reg_offset == pcih_pkg::OFS_INTR) &&
                (in_reg.byte_lane == pcih_pkg::LANE_0)) begin
                irq_line_reg <= in_reg.write_value;
            end
        end
    end

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.op          <= s_op;
            in_reg.reg_offset  <= s_reg_offset;
            in_reg.byte_lane   <= s_byte_lane;
            in_reg.write_value <= s_write_value;
        end
    end

    // Result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg    <= is_write ? 32'd0 : rd_data;
            out_changed_reg <= is_write && changed;
        end
    end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the PCI type-0 configuration header unit.
// Holds a shadow copy of the header state to predict every reply. Depends on pcih_pkg and the RTL.

module tb_top;

    localparam int BAR_COUNT   = 6;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        logic [31:0] read_data;
        logic        regions_changed;
    } reply_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_op;
    logic [7:0]  s_reg_offset;
    logic [1:0]  s_byte_lane;
    logic [7:0]  s_write_value;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_read_data;
    logic        m_regions_changed;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    // Shadow configuration
    logic [31:0] sh_id;
    logic [31:0] sh_class;
    logic [15:0] sh_hdr_pin;
    logic [15:0] sh_cmd_wmask;
    logic [15:0] sh_cmd_reset;
    logic [15:0] sh_status;
    logic [41:0] sh_layout;
    logic [4:0]  sh_rom_size;

    // Shadow header state
    logic [31:0] sh_bar [BAR_COUNT];
    logic [31:0] sh_rom;
    logic [15:0] sh_cmd;
    logic [7:0]  sh_cache_line;
    logic [7:0]  sh_latency;
    logic [7:0]  sh_irq_line;

    reply_t expected_replies [$];
    int     mismatch_count = 0;
    bit     sender_no_idle = 1'b0;
    bit     receiver_no_idle = 1'b0;
    bit     receiver_hold_req = 1'b0;

    pci_type0_config_header_unit #(.NUM_BARS(BAR_COUNT)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_reg_offset(s_reg_offset),
        .s_byte_lane(s_byte_lane), .s_write_value(s_write_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_read_data(m_read_data),
        .m_regions_changed(m_regions_changed),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Region size mask for 2^lg bytes
    function automatic logic [31:0] size_mask(logic [4:0] lg);
        return ~((32'd1 << lg) - 32'd1);
    endfunction

    function automatic logic [31:0] kind_type_bits(logic [1:0] kind);
        if (kind == pcih_pkg::KIND_IO)
            return pcih_pkg::TYPE_BITS_IO;
        if (kind == pcih_pkg::KIND_PREFETCH)
            return pcih_pkg::TYPE_BITS_PREF;
        return 32'd0;
    endfunction

    // Predict the reply to one access and update the shadow state
    function automatic reply_t header_access(logic op, logic [7:0] ofs, logic [1:0] lane,
                                             logic [7:0] val);
        reply_t      r;
        logic [31:0] lane_mask;
        logic [31:0] ins;
        logic [31:0] was;
        logic [15:0] cmd_was;
        logic [15:0] incoming;
        logic [6:0]  field;
        int          idx;
        r = '0;
        lane_mask = 32'hFF << (8 * lane);
        ins = {24'd0, val} << (8 * lane);
        if (ofs >= pcih_pkg::OFS_BAR_FIRST && ofs <= pcih_pkg::OFS_BAR_LAST) begin
            // BAR window: unaligned offsets still pick a BAR
            idx = int'((ofs - pcih_pkg::OFS_BAR_FIRST) >> 2);
            field = sh_layout[pcih_pkg::LAYOUT_BITS * idx +: pcih_pkg::LAYOUT_BITS];
            if (idx < BAR_COUNT && field[4:0] != 5'd0) begin
                if (op == pcih_pkg::OP_READ) begin
                    r.read_data = (sh_bar[idx] & size_mask(field[4:0])) |
                                  kind_type_bits(field[6:5]);
                end else begin
                    was = sh_bar[idx];
                    sh_bar[idx] = (was & ~lane_mask) | ins;
                    r.regions_changed = (sh_bar[idx] != was);
                end
            end
        end else if (op == pcih_pkg::OP_READ) begin
            case (ofs)
                pcih_pkg::OFS_ID:    r.read_data = sh_id;
                pcih_pkg::OFS_CMD:   r.read_data = {sh_status, sh_cmd};
                pcih_pkg::OFS_CLASS: r.read_data = sh_class;
                pcih_pkg::OFS_MISC:  r.read_data = {8'h00, sh_hdr_pin[15:8], sh_latency,
                                                    sh_cache_line};
                pcih_pkg::OFS_ROM: begin
                    if (sh_rom_size != 5'd0)
                        r.read_data = (sh_rom & size_mask(sh_rom_size)) |
                                      (sh_rom & pcih_pkg::ROM_ENABLE);
                end
                pcih_pkg::OFS_INTR:  r.read_data = {16'h0000, sh_hdr_pin[7:0], sh_irq_line};
                default: ;
            endcase
        end else begin
            case (ofs)
                pcih_pkg::OFS_CMD: begin
                    // status half is read-only
                    if (lane <= pcih_pkg::LANE_1) begin
                        cmd_was = sh_cmd;
                        incoming = (cmd_was & ~lane_mask[15:0]) | ins[15:0];
                        sh_cmd = (cmd_was & ~sh_cmd_wmask) | (incoming & sh_cmd_wmask) |
                                 sh_cmd_reset;
                        r.regions_changed = (sh_cmd != cmd_was);
                    end
                end
                pcih_pkg::OFS_MISC: begin
                    if (lane == pcih_pkg::LANE_0)
                        sh_cache_line = val;
                    else if (lane == pcih_pkg::LANE_1)
                        sh_latency = val;
                end
                pcih_pkg::OFS_ROM: begin
                    if (sh_rom_size != 5'd0) begin
                        was = sh_rom;
                        sh_rom = (was & ~lane_mask) | ins;
                        r.regions_changed = (sh_rom != was);
                    end
                end
                pcih_pkg::OFS_INTR: begin
                    if (lane == pcih_pkg::LANE_0)
                        sh_irq_line = val;
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    // Check each reply transfer, then predict each access transfer
    always @(posedge aclk) begin : reply_tracker
        reply_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    flag_mismatch("reply with none pending", 32'd0, m_read_data);
                end else begin
                    want = expected_replies.pop_front();
                    if (m_read_data !== want.read_data)
                        flag_mismatch("read_data", want.read_data, m_read_data);
                    if (m_regions_changed !== want.regions_changed)
                        flag_mismatch("regions_changed", {31'd0, want.regions_changed},
                                      {31'd0, m_regions_changed});
                end
            end
            if (s_valid && s_ready)
                expected_replies.push_back(header_access(s_op, s_reg_offset, s_byte_lane,
                                                         s_write_value));
        end
    end

    // Receiver: random wait before each transfer, or a long hold on request
    initial begin : receiver
        int gap;
        m_ready = 1'b0;
        forever begin
            if (receiver_hold_req) begin
                receiver_hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = receiver_no_idle ? 0 : $urandom_range(0, 10);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // One APB register write, then the bus goes idle; the shadow copy follows at the access edge
    task automatic apb_reg_write(logic [2:0] idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            pcih_pkg::CFG_ID_WORD:      sh_id = value[31:0];
            pcih_pkg::CFG_CLASS_WORD:   sh_class = value[31:0];
            pcih_pkg::CFG_HDR_PIN:      sh_hdr_pin = value[15:0];
            pcih_pkg::CFG_CMD_WMASK:    sh_cmd_wmask = value[15:0];
            pcih_pkg::CFG_CMD_RESET:    sh_cmd_reset = value[15:0];
            pcih_pkg::CFG_STATUS_RESET: sh_status = value[15:0];
            pcih_pkg::CFG_BAR_LAYOUT:   sh_layout = value[41:0];
            pcih_pkg::CFG_ROM_SIZE:     sh_rom_size = value[4:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_config(logic [31:0] id, logic [31:0] cls, logic [15:0] hdr,
                               logic [15:0] wmask, logic [15:0] crst, logic [15:0] status,
                               logic [41:0] layout, logic [4:0] rom);
        apb_reg_write(pcih_pkg::CFG_ID_WORD, {32'd0, id});
        apb_reg_write(pcih_pkg::CFG_CLASS_WORD, {32'd0, cls});
        apb_reg_write(pcih_pkg::CFG_HDR_PIN, {48'd0, hdr});
        apb_reg_write(pcih_pkg::CFG_CMD_WMASK, {48'd0, wmask});
        apb_reg_write(pcih_pkg::CFG_CMD_RESET, {48'd0, crst});
        apb_reg_write(pcih_pkg::CFG_STATUS_RESET, {48'd0, status});
        apb_reg_write(pcih_pkg::CFG_BAR_LAYOUT, {22'd0, layout});
        apb_reg_write(pcih_pkg::CFG_ROM_SIZE, {59'd0, rom});
    endtask

    task automatic load_random_config();
        logic [41:0] layout;
        logic [4:0]  sz;
        logic [1:0]  kind;
        logic [4:0]  rom;
        layout = '0;
        for (int i = 0; i < BAR_COUNT; i++) begin
            sz = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
            kind = 2'($urandom_range(0, 3));
            layout[pcih_pkg::LAYOUT_BITS * i +: pcih_pkg::LAYOUT_BITS] = {kind, sz};
        end
        rom = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
        load_config($urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), layout, rom);
    endtask

    // Offer one access and return at the edge where it transfers
    task automatic send_access(logic op, logic [7:0] ofs, logic [1:0] lane, logic [7:0] val);
        int gap;
        gap = sender_no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_reg_offset  <= ofs;
        s_byte_lane   <= lane;
        s_write_value <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Mostly aligned header offsets, else offsets in or just past the BAR window, else anything
    task automatic send_random_access();
        logic [7:0] ofs;
        logic [7:0] val;
        int         sel;
        sel = $urandom_range(0, 99);
        if (sel < 65)
            ofs = {2'b00, 4'($urandom_range(0, 15)), 2'b00};
        else if (sel < 85)
            ofs = 8'($urandom_range(pcih_pkg::OFS_BAR_FIRST, pcih_pkg::OFS_BAR_LAST + 8'd3));
        else
            ofs = 8'($urandom_range(0, 255));
        sel = $urandom_range(0, 9);
        if (sel < 2)
            val = 8'h00;
        else if (sel < 4)
            val = 8'hFF;
        else
            val = 8'($urandom);
        send_access(($urandom_range(0, 1) == 1) ? pcih_pkg::OP_WRITE : pcih_pkg::OP_READ,
                    ofs, 2'($urandom_range(0, 3)), val);
    endtask

    // Stop offering and wait until every reply is in and the pipe is quiet
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Absent BARs and ROM straight after reset
    task automatic test_reset_state();
        send_access(pcih_pkg::OP_WRITE, pcih_pkg::OFS_BAR_FIRST, pcih_pkg::LANE_0, 8'hFF);
        send_access(pcih_pkg::OP_READ, pcih_pkg::OFS_BAR_FIRST, pcih_pkg::LANE_0, 8'h00);
        send_access(pcih_pkg::OP_WRITE, pcih_pkg::OFS_ROM, pcih_pkg::LANE_0, 8'hFF);
        wait_idle();
    endtask

    // Header registers, lane rules and read-only bytes under one fixed layout
    task automatic test_directed();
        logic [41:0] layout;
        layout = {2'd1, 5'd1, 2'd0, 5'd0, 2'd3, 5'd4, 2'd2, 5'd12, 2'd1, 5'd2, 2'd0, 5'd31};
        load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF,
                    layout, 5'd11);
        send_access(pcih_pkg::OP_WRITE, pcih_pkg::OFS_BAR_FIRST, pcih_pkg::LANE_0, 8'hFF);
        send_access(pcih_pkg::OP_WRITE, pcih_pkg::OFS_BAR_FIRST, 2'd3, 8'hFF);
        send_access(pcih_pkg::OP_READ, pcih_pkg::OFS_BAR_FIRST, pcih_pkg::LANE_0, 8'h00);
        // unaligned offset inside the BAR window
        send_access(pcih_pkg::OP_WRITE, pcih_pkg::OFS_BAR_FIRST + 8'd3, pcih_pkg::LANE_1,
                    8'hAB);
        send_access(pcih_pkg::OP_READ, pcih_pkg::OFS_BAR_FIRST + 8'd2, pcih_pkg::LANE_0,
                    8'h00);
        send_access(pcih_pkg::OP_WRITE, pcih_pkg::OFS_BAR_FIRST + 8'd4, pcih_pkg::LANE_0,
                    8'hFF);
        send_access(pcih_pkg::OP_READ, pcih_pkg::OFS_BAR_FIRST + 8'd4, pcih_pkg::LANE_0,
                    8'h00);
        send_access(pcih_pkg::OP_WRITE, pcih_pkg::OFS_BAR_FIRST + 8'd8, pcih_pkg::LANE_1,
                    8'hFF);
        send_access(pcih_pkg::OP_READ, pcih_pkg::OFS_BAR_FIRST + 8'd8, pcih_pkg::LANE_0,
                    8'h00);
        // reserved kind reads as memory
        send_access(pcih_pkg::OP_READ, pcih_pkg::OFS_BAR_FIRST + 8'd12, pcih_pkg::LANE_0,
                    8'h00);
        // absent BAR
        send_access(pcih_pkg::OP_WRITE, pcih_pkg::OFS_BAR_FIRST + 8'd16, pcih_pkg::LANE_0,
                    8'hFF);
        send_access(pcih_pkg::OP_READ, pcih_pkg::OFS_BAR_FIRST + 8'd16, pcih_pkg::LANE_0,
                    8'h00);
        send_access(pcih_pkg::OP_WRITE, pcih_pkg::OFS_CMD, pcih_pkg::LANE_0, 8'hFF);
        send_access(pcih_pkg::OP_WRITE, pcih_pkg::OFS_CMD, 2'd2, 8'hFF);
        send_access(pcih_pkg::OP_READ, pcih_pkg::OFS_CMD, pcih_pkg::LANE_0, 8'h00);
        // BIST and header type are read-only
        send_access(pcih_pkg::OP_WRITE, pcih_pkg::OFS_MISC, 2'd3, 8'hFF);
        send_access(pcih_pkg::OP_WRITE, pcih_pkg::OFS_MISC, pcih_pkg::LANE_0, 8'h40);
        send_access(pcih_pkg::OP_READ, pcih_pkg::OFS_MISC, pcih_pkg::LANE_0, 8'h00);
        send_access(pcih_pkg::OP_WRITE, pcih_pkg::OFS_ROM, pcih_pkg::LANE_0, 8'h01);
        send_access(pcih_pkg::OP_WRITE, pcih_pkg::OFS_ROM, 2'd3, 8'hFF);
        send_access(pcih_pkg::OP_READ, pcih_pkg::OFS_ROM, pcih_pkg::LANE_0, 8'h00);
        // interrupt pin is read-only
        send_access(pcih_pkg::OP_WRITE, pcih_pkg::OFS_INTR, pcih_pkg::LANE_1, 8'hFF);
        send_access(pcih_pkg::OP_WRITE, pcih_pkg::OFS_INTR, pcih_pkg::LANE_0, 8'h0B);
        send_access(pcih_pkg::OP_READ, pcih_pkg::OFS_INTR, pcih_pkg::LANE_0, 8'h00);
        send_access(pcih_pkg::OP_READ, 8'hFF, pcih_pkg::LANE_0, 8'h00);
        send_access(pcih_pkg::OP_WRITE, pcih_pkg::OFS_CMD + 8'd1, pcih_pkg::LANE_0, 8'hFF);
        wait_idle();
    endtask

    // Random traffic over a run of configurations, extremes first
    task automatic test_config_sweep();
        logic [41:0] tiny_layout;
        tiny_layout = {2'd3, 5'd1, 2'd2, 5'd1, 2'd1, 5'd1, 2'd0, 5'd1, 2'd2, 5'd1, 2'd1, 5'd1};
        load_config('0, '0, '0, '0, '0, '0, '0, '0);
        repeat (100) send_random_access();
        wait_idle();
        load_config('1, '1, '1, '1, '1, '1, '1, '1);
        repeat (120) send_random_access();
        wait_idle();
        load_config($urandom, $urandom, 16'($urandom), 16'hFFFF, 16'h0000, 16'($urandom),
                    tiny_layout, 5'd1);
        repeat (130) send_random_access();
        wait_idle();
        for (int phase = 0; phase < 5; phase++) begin
            load_random_config();
            // one phase runs flat out on both sides
            sender_no_idle = (phase == 2);
            receiver_no_idle = (phase == 2);
            repeat (130) send_random_access();
            wait_idle();
        end
        sender_no_idle = 1'b0;
        receiver_no_idle = 1'b0;
    endtask

    // Receiver stalls for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        load_random_config();
        receiver_hold_req = 1'b1;
        sender_no_idle = 1'b1;
        repeat (40) send_random_access();
        sender_no_idle = 1'b0;
        wait_idle();
    endtask

    // Sender pauses until every reply is in, then carries on
    task automatic test_drain_pause();
        repeat (20) send_random_access();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (20) send_random_access();
        wait_idle();
    endtask

    initial begin : main
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_op          = pcih_pkg::OP_READ;
        s_reg_offset  = '0;
        s_byte_lane   = '0;
        s_write_value = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        sh_id = '0;
        sh_class = '0;
        sh_hdr_pin = '0;
        sh_cmd_wmask = '0;
        sh_cmd_reset = '0;
        sh_status = '0;
        sh_layout = '0;
        sh_rom_size = '0;
        for (int i = 0; i < BAR_COUNT; i++)
            sh_bar[i] = '0;
        sh_rom = '0;
        sh_cmd = '0;
        sh_cache_line = '0;
        sh_latency = '0;
        sh_irq_line = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_reset_state();
        test_directed();
        test_config_sweep();
        test_backpressure();
        test_drain_pause();

        wait_idle();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
